[rtl/core/stereo_peak_meter_with_hold_macros.svh]
// Assertion macros for the checker file.
`ifndef STEREO_PEAK_METER_WITH_HOLD_MACROS_SVH
`define STEREO_PEAK_METER_WITH_HOLD_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stereo peak meter: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stereo peak meter: assertion failed");

`endif

[rtl/core/spm_pkg.sv]
`timescale 1ns / 1ps

package spm_pkg;

  localparam int LEVEL_WIDTH_DEF = 24;
  localparam int TIMER_WIDTH_DEF = 20;

  // Fixed field widths.
  localparam int ELAPSED_WIDTH    = 16;
  localparam int HOLD_SAMP_WIDTH  = 20;
  localparam int DECAY_WIDTH      = 16;
  localparam int HOLD_DECAY_WIDTH = 8;
  localparam int CFG_DATA_WIDTH   = 20;
  localparam int CFG_INDEX_WIDTH  = 2;
  localparam int PEAK_FALL_WIDTH  = ELAPSED_WIDTH + DECAY_WIDTH;
  localparam int HOLD_FALL_WIDTH  = ELAPSED_WIDTH + HOLD_DECAY_WIDTH;

  // Width for level arithmetic: a 32-bit level less a 32-bit fall fits in 34 bits.
  localparam int CALC_WIDTH = 34;

  // -100 dB and -96 dB in 1/65536 dB units.
  localparam int FLOOR_DB = -100 * 65536;
  localparam int SHOW_DB  = -96 * 65536;

  localparam logic [HOLD_SAMP_WIDTH-1:0]  HOLD_SAMPLES_RST = HOLD_SAMP_WIDTH'(48000);
  localparam logic [DECAY_WIDTH-1:0]      DECAY_RST        = DECAY_WIDTH'(27);
  localparam logic [HOLD_DECAY_WIDTH-1:0] HOLD_DECAY_RST   = HOLD_DECAY_WIDTH'(57);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_HOLD_SAMPLES = 2'd0,
    REG_DECAY        = 2'd1,
    REG_HOLD_DECAY   = 2'd2
  } reg_index_t;

endpackage

[rtl/core/spm_if.sv]
`timescale 1ns / 1ps

interface spm_in_if #(
  parameter int LEVEL_WIDTH = spm_pkg::LEVEL_WIDTH_DEF
);
  import spm_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [LEVEL_WIDTH-1:0] left_level;
  logic signed [LEVEL_WIDTH-1:0] right_level;
  logic [ELAPSED_WIDTH-1:0]      elapsed_samples;

  modport source (output valid, left_level, right_level, elapsed_samples, input ready);
  modport sink   (input valid, left_level, right_level, elapsed_samples, output ready);
endinterface

interface spm_out_if #(
  parameter int LEVEL_WIDTH = spm_pkg::LEVEL_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [LEVEL_WIDTH-1:0] left_peak_db;
  logic signed [LEVEL_WIDTH-1:0] right_peak_db;
  logic signed [LEVEL_WIDTH-1:0] left_hold_db;
  logic signed [LEVEL_WIDTH-1:0] right_hold_db;

  modport source (output valid, left_peak_db, right_peak_db, left_hold_db, right_hold_db,
                  input ready);
  modport sink   (input valid, left_peak_db, right_peak_db, left_hold_db, right_hold_db,
                  output ready);
endinterface

[rtl/core/spm_chan.sv]
`timescale 1ns / 1ps

module spm_chan #(
  parameter int LEVEL_WIDTH = spm_pkg::LEVEL_WIDTH_DEF,
  parameter int TIMER_WIDTH = spm_pkg::TIMER_WIDTH_DEF
) (
  input  logic signed [LEVEL_WIDTH-1:0]      level,
  input  logic [spm_pkg::ELAPSED_WIDTH-1:0]  elapsed,
  input  logic [spm_pkg::PEAK_FALL_WIDTH-1:0] peak_fall,
  input  logic [spm_pkg::HOLD_FALL_WIDTH-1:0] hold_fall,
  input  logic [TIMER_WIDTH-1:0]             reload,
  input  logic                               hold_en,
  input  logic signed [LEVEL_WIDTH-1:0]      peak,
  input  logic signed [LEVEL_WIDTH-1:0]      hold,
  input  logic [TIMER_WIDTH-1:0]             timer,
  output logic signed [LEVEL_WIDTH-1:0]      peak_next,
  output logic signed [LEVEL_WIDTH-1:0]      hold_next,
  output logic [TIMER_WIDTH-1:0]             timer_next,
  output logic signed [LEVEL_WIDTH-1:0]      peak_show,
  output logic signed [LEVEL_WIDTH-1:0]      hold_show
);
  import spm_pkg::*;

  localparam int CW  = CALC_WIDTH;
  localparam int TCW = (TIMER_WIDTH > ELAPSED_WIDTH) ? TIMER_WIDTH : ELAPSED_WIDTH;

  localparam logic signed [LEVEL_WIDTH-1:0] SILENCE = {1'b1, {(LEVEL_WIDTH-1){1'b0}}};
  localparam logic signed [CW-1:0] SILENCE_C = CW'(SILENCE);
  localparam logic signed [CW-1:0] FLOOR_C   = CW'(FLOOR_DB);
  localparam logic signed [CW-1:0] SHOW_C    = CW'(SHOW_DB);
  // When the level range does not reach -96 dB, silence is shown instead.
  localparam logic signed [LEVEL_WIDTH-1:0] SHOW_V =
    (SHOW_C < SILENCE_C) ? SILENCE : LEVEL_WIDTH'(SHOW_C);

  function automatic logic signed [LEVEL_WIDTH-1:0] fall(
    input logic signed [LEVEL_WIDTH-1:0] lvl,
    input logic [PEAK_FALL_WIDTH-1:0]    amt
  );
    logic signed [CW-1:0] r;
    r = CW'(lvl) - $signed(CW'(amt));
    if (r < FLOOR_C || r < SILENCE_C) begin
      return SILENCE;
    end
    return LEVEL_WIDTH'(r);
  endfunction

  function automatic logic signed [LEVEL_WIDTH-1:0] shown(
    input logic signed [LEVEL_WIDTH-1:0] lvl
  );
    return (CW'(lvl) > FLOOR_C) ? lvl : SHOW_V;
  endfunction

  logic signed [LEVEL_WIDTH-1:0] peak_in;
  logic [TIMER_WIDTH-1:0]        timer_in;
  logic signed [LEVEL_WIDTH-1:0] hold_up;
  logic [TIMER_WIDTH-1:0]        timer_up;

  always_comb begin
    // A louder block replaces the peak and restarts the hold time.
    if (level > peak) begin
      peak_in  = level;
      timer_in = reload;
    end else begin
      peak_in  = peak;
      timer_in = timer;
    end

    // Only a peak above the floor decays.
    if (CW'(peak_in) > FLOOR_C) begin
      peak_next = fall(peak_in, peak_fall);
    end else begin
      peak_next = peak_in;
    end

    if (peak_next > hold) begin
      hold_up  = peak_next;
      timer_up = reload;
    end else begin
      hold_up  = hold;
      timer_up = timer_in;
    end

    if (!hold_en) begin
      hold_next  = hold;
      timer_next = timer_in;
    end else if (TCW'(timer_up) > TCW'(elapsed)) begin
      hold_next  = hold_up;
      timer_next = TIMER_WIDTH'(TCW'(timer_up) - TCW'(elapsed));
    end else begin
      hold_next  = fall(hold_up, PEAK_FALL_WIDTH'(hold_fall));
      timer_next = '0;
    end

    peak_show = shown(peak_next);
    hold_show = shown(hold_next);
  end

endmodule

[rtl/core/stereo_peak_meter_with_hold.sv]
`timescale 1ns / 1ps
// Stereo peak meter with peak hold, levels in 1/65536 dB.
// An accepted item passes through the input stage and then the output register,
// where its result waits until it is taken.
// Throughput: one item per cycle unless results stall; the output register and
// the input stage let a new item in while a finished result waits to be taken.
// Reset (rst, synchronous, active high) silences peaks and holds, clears timers
// and restores the register defaults; the block is ready in the next cycle.

module stereo_peak_meter_with_hold #(
  parameter int LEVEL_WIDTH = spm_pkg::LEVEL_WIDTH_DEF,
  parameter int TIMER_WIDTH = spm_pkg::TIMER_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  spm_in_if.sink                              meter_in,
  spm_out_if.source                           meter_out,
  input  logic                                wr_en,
  input  logic [spm_pkg::CFG_INDEX_WIDTH-1:0] wr_index,
  input  logic [spm_pkg::CFG_DATA_WIDTH-1:0]  wr_data
);
  import spm_pkg::*;

  localparam logic signed [LEVEL_WIDTH-1:0] SILENCE = {1'b1, {(LEVEL_WIDTH-1){1'b0}}};

  // Configuration registers.
  logic [HOLD_SAMP_WIDTH-1:0]  hold_samples;
  logic [DECAY_WIDTH-1:0]      decay_per_sample;
  logic [HOLD_DECAY_WIDTH-1:0] hold_decay_per_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_samples          <= HOLD_SAMPLES_RST;
      decay_per_sample      <= DECAY_RST;
      hold_decay_per_sample <= HOLD_DECAY_RST;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_HOLD_SAMPLES: hold_samples          <= wr_data;
        REG_DECAY:        decay_per_sample      <= wr_data[DECAY_WIDTH-1:0];
        REG_HOLD_DECAY:   hold_decay_per_sample <= wr_data[HOLD_DECAY_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Input stage. The two fall amounts depend only on the item and the registers,
  // so they are multiplied on the way in and the stage holds the products.
  logic                             s1_valid;
  logic signed [LEVEL_WIDTH-1:0]    s1_level [2];
  logic [ELAPSED_WIDTH-1:0]         s1_elapsed;
  logic [PEAK_FALL_WIDTH-1:0]       s1_peak_fall;
  logic [HOLD_FALL_WIDTH-1:0]       s1_hold_fall;

  logic in_take;
  logic s1_move;

  // The stage moves on whenever the output register is empty or being emptied.
  assign s1_move        = s1_valid && (!meter_out.valid || meter_out.ready);
  assign meter_in.ready = !s1_valid || !meter_out.valid || meter_out.ready;
  assign in_take        = meter_in.valid && meter_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (meter_in.ready) begin
      s1_valid <= meter_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_level[0]  <= meter_in.left_level;
      s1_level[1]  <= meter_in.right_level;
      s1_elapsed   <= meter_in.elapsed_samples;
      s1_peak_fall <= PEAK_FALL_WIDTH'(meter_in.elapsed_samples) *
                      PEAK_FALL_WIDTH'(decay_per_sample);
      s1_hold_fall <= HOLD_FALL_WIDTH'(meter_in.elapsed_samples) *
                      HOLD_FALL_WIDTH'(hold_decay_per_sample);
    end
  end

  // Per-channel meter state, updated as an item leaves the input stage.
  logic signed [LEVEL_WIDTH-1:0] peak_level [2];
  logic signed [LEVEL_WIDTH-1:0] hold_level [2];
  logic [TIMER_WIDTH-1:0]        hold_timer [2];

  logic signed [LEVEL_WIDTH-1:0] peak_level_next [2];
  logic signed [LEVEL_WIDTH-1:0] hold_level_next [2];
  logic [TIMER_WIDTH-1:0]        hold_timer_next [2];
  logic signed [LEVEL_WIDTH-1:0] peak_show [2];
  logic signed [LEVEL_WIDTH-1:0] hold_show [2];

  logic [TIMER_WIDTH-1:0] reload;
  logic                   hold_en;

  // The timer reload is the hold length cut or padded to the timer width, while
  // hold is enabled by the full register being nonzero.
  assign reload  = TIMER_WIDTH'(hold_samples);
  assign hold_en = (hold_samples != '0);

  for (genvar c = 0; c < 2; c++) begin : g_chan
    spm_chan #(
      .LEVEL_WIDTH (LEVEL_WIDTH),
      .TIMER_WIDTH (TIMER_WIDTH)
    ) u_chan (
      .level      (s1_level[c]),
      .elapsed    (s1_elapsed),
      .peak_fall  (s1_peak_fall),
      .hold_fall  (s1_hold_fall),
      .reload     (reload),
      .hold_en    (hold_en),
      .peak       (peak_level[c]),
      .hold       (hold_level[c]),
      .timer      (hold_timer[c]),
      .peak_next  (peak_level_next[c]),
      .hold_next  (hold_level_next[c]),
      .timer_next (hold_timer_next[c]),
      .peak_show  (peak_show[c]),
      .hold_show  (hold_show[c])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        peak_level[c] <= SILENCE;
        hold_level[c] <= SILENCE;
        hold_timer[c] <= '0;
      end else if (s1_move) begin
        peak_level[c] <= peak_level_next[c];
        hold_level[c] <= hold_level_next[c];
        hold_timer[c] <= hold_timer_next[c];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      meter_out.valid <= 1'b0;
    end else if (!meter_out.valid || meter_out.ready) begin
      meter_out.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      meter_out.left_peak_db  <= peak_show[0];
      meter_out.right_peak_db <= peak_show[1];
      meter_out.left_hold_db  <= hold_show[0];
      meter_out.right_hold_db <= hold_show[1];
    end
  end

endmodule

[rtl/core/spm_checker.sv]
`timescale 1ns / 1ps
`include "stereo_peak_meter_with_hold_macros.svh"

module spm_checker #(
  parameter int LEVEL_WIDTH = spm_pkg::LEVEL_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [LEVEL_WIDTH-1:0] left_peak_db,
  input logic [LEVEL_WIDTH-1:0] right_peak_db,
  input logic [LEVEL_WIDTH-1:0] left_hold_db,
  input logic [LEVEL_WIDTH-1:0] right_hold_db
);

  logic [4*LEVEL_WIDTH-1:0] reading;

  assign reading = {left_peak_db, right_peak_db, left_hold_db, right_hold_db};

  // A stalled result keeps its values.
  `SPM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(reading))

  // An accepted item reaches the output when the output side is taking results.
  `SPM_ASSERT_NEXT(a_latency, (in_valid && in_ready) ##1 out_ready, out_valid)

  // Input is refused only while both the stage and a stalled result are full.
  `SPM_ASSERT_SAME(a_ready, !in_ready, out_valid && !out_ready)

endmodule

bind stereo_peak_meter_with_hold spm_checker #(
  .LEVEL_WIDTH (LEVEL_WIDTH)
) u_spm_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (meter_in.valid),
  .in_ready      (meter_in.ready),
  .out_valid     (meter_out.valid),
  .out_ready     (meter_out.ready),
  .left_peak_db  (meter_out.left_peak_db),
  .right_peak_db (meter_out.right_peak_db),
  .left_hold_db  (meter_out.left_hold_db),
  .right_hold_db (meter_out.right_hold_db)
);

[bench/stereo_peak_meter_with_hold_test.sv]
`timescale 1ns / 1ps

module stereo_peak_meter_with_hold_test;
  import spm_pkg::*;

  localparam int LW = LEVEL_WIDTH_DEF;
  localparam int TW = TIMER_WIDTH_DEF;

  // The write port decodes two index bits, so one index names no register at all.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE = 2'd3;

  // Generous ceiling on the run length, far above the slowest correct run.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  localparam logic signed [LW-1:0] SILENCE_LVL = {1'b1, {(LW-1){1'b0}}};
  localparam logic signed [LW-1:0] MAX_LVL     = {1'b0, {(LW-1){1'b1}}};
  localparam logic signed [LW-1:0] FLOOR_LVL   = LW'(FLOOR_DB);
  localparam logic signed [LW-1:0] SHOW_LVL    = LW'(SHOW_DB);

  typedef struct packed {
    logic signed [LW-1:0]     left;
    logic signed [LW-1:0]     right;
    logic [ELAPSED_WIDTH-1:0] elapsed;
  } meter_update_t;

  typedef struct packed {
    logic signed [LW-1:0] peak_l;
    logic signed [LW-1:0] peak_r;
    logic signed [LW-1:0] left_hold;
    logic signed [LW-1:0] right_hold;
  } meter_reading_t;

  logic clk;
  logic rst;
  logic wr_en;
  logic [CFG_INDEX_WIDTH-1:0] wr_index;
  logic [CFG_DATA_WIDTH-1:0]  wr_data;

  spm_in_if  #(.LEVEL_WIDTH(LW)) meter_in ();
  spm_out_if #(.LEVEL_WIDTH(LW)) meter_out ();

  stereo_peak_meter_with_hold #(
    .LEVEL_WIDTH(LW),
    .TIMER_WIDTH(TW)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .meter_in(meter_in),
    .meter_out(meter_out),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  // Our own copy of the meter: registers and per-channel state.
  logic [HOLD_SAMP_WIDTH-1:0]  hold_len;
  logic [DECAY_WIDTH-1:0]      peak_decay;
  logic [HOLD_DECAY_WIDTH-1:0] hold_decay;
  logic signed [LW-1:0]        peak_lvl [2];
  logic signed [LW-1:0]        hold_lvl [2];
  logic [TW-1:0]               hold_tmr [2];

  meter_update_t  pending_updates[$];
  meter_reading_t expected_readings[$];

  // The driver needs to know, at the falling edge, whether the item on the bus was
  // taken at the rising edge before it.
  logic        in_sent;
  bit          gaps_on;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned updates_taken;
  int unsigned readings_checked;
  int unsigned settings_used;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Gap lengths: mostly none or short, now and then a long one. With gaps switched
  // off the bus runs flat out.
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // A fall never wraps: anything that lands below -100 dB, or below the level range,
  // is silence.
  function automatic logic signed [LW-1:0] lowered_level(logic signed [LW-1:0] lvl,
                                                         longint unsigned amount);
    longint r;
    r = longint'(lvl) - longint'(amount);
    if (r < longint'(FLOOR_DB) || r < longint'(SILENCE_LVL)) return SILENCE_LVL;
    return r[LW-1:0];
  endfunction

  // Anything at or below -100 dB is displayed as -96 dB.
  function automatic logic signed [LW-1:0] displayed_level(logic signed [LW-1:0] lvl);
    if (longint'(lvl) > longint'(FLOOR_DB)) return lvl;
    return SHOW_LVL;
  endfunction

  function automatic void advance_channel(int c, logic signed [LW-1:0] lvl_in,
                                          logic [ELAPSED_WIDTH-1:0] elapsed);
    logic [TW-1:0] reload;
    reload = hold_len[TW-1:0];
    // A louder block takes over the peak and restarts the hold timer.
    if (lvl_in > peak_lvl[c]) begin
      peak_lvl[c] = lvl_in;
      hold_tmr[c] = reload;
    end
    // Only a peak above the floor decays; one at or below it sits still.
    if (longint'(peak_lvl[c]) > longint'(FLOOR_DB))
      peak_lvl[c] = lowered_level(peak_lvl[c],
                                  longint'(elapsed) * longint'(peak_decay));
    // With hold disabled this step leaves the hold level and timer alone.
    if (hold_len != '0) begin
      if (peak_lvl[c] > hold_lvl[c]) begin
        hold_lvl[c] = peak_lvl[c];
        hold_tmr[c] = reload;
      end
      if (hold_tmr[c] > elapsed) begin
        hold_tmr[c] = hold_tmr[c] - elapsed;
      end else begin
        hold_tmr[c] = '0;
        hold_lvl[c] = lowered_level(hold_lvl[c],
                                    longint'(elapsed) * longint'(hold_decay));
      end
    end
  endfunction

  function automatic meter_reading_t advance_meter(meter_update_t u);
    meter_reading_t r;
    advance_channel(0, u.left, u.elapsed);
    advance_channel(1, u.right, u.elapsed);
    r.peak_l     = displayed_level(peak_lvl[0]);
    r.peak_r     = displayed_level(peak_lvl[1]);
    r.left_hold  = displayed_level(hold_lvl[0]);
    r.right_hold = displayed_level(hold_lvl[1]);
    return r;
  endfunction

  function automatic void compare_field(string name, logic signed [LW-1:0] want,
                                        logic signed [LW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Levels: silence, full scale, values around -100 dB, a musical range from -100 dB
  // to +10 dB, and raw random patterns so that every bit of the field moves.
  function automatic logic signed [LW-1:0] pick_level();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return SILENCE_LVL;
    if (r < 12) return MAX_LVL;
    if (r < 30) return LW'(FLOOR_DB - 2000 + int'($urandom_range(0, 4000)));
    if (r < 70) return LW'(FLOOR_DB + int'($urandom_range(0, 7208960)));
    return LW'($urandom());
  endfunction

  function automatic logic [ELAPSED_WIDTH-1:0] pick_elapsed();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return '0;
    if (r < 17) return '1;
    if (r < 30) return ELAPSED_WIDTH'($urandom());
    if (r < 60) return ELAPSED_WIDTH'($urandom_range(1, 64));
    return ELAPSED_WIDTH'($urandom_range(64, 2048));
  endfunction

  function automatic void queue_update(logic signed [LW-1:0] l, logic signed [LW-1:0] r,
                                       logic [ELAPSED_WIDTH-1:0] e);
    meter_update_t u;
    u.left    = l;
    u.right   = r;
    u.elapsed = e;
    pending_updates.push_back(u);
  endfunction

  // Cycle counter and watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d readings outstanding.",
               cycle_count, expected_readings.size());
      $display("stereo_peak_meter_with_hold_test: FAIL");
      $finish;
    end
  end

  // At each rising edge the predictor follows register writes and accepted items, and
  // each reading that leaves the block is checked against the oldest prediction.
  always @(posedge clk) begin : scoreboard
    meter_reading_t want;
    if (rst) begin
      in_sent    <= 1'b0;
      hold_len   = HOLD_SAMPLES_RST;
      peak_decay = DECAY_RST;
      hold_decay = HOLD_DECAY_RST;
      for (int c = 0; c < 2; c++) begin
        peak_lvl[c] = SILENCE_LVL;
        hold_lvl[c] = SILENCE_LVL;
        hold_tmr[c] = '0;
      end
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_HOLD_SAMPLES: hold_len   = wr_data[HOLD_SAMP_WIDTH-1:0];
          REG_DECAY:        peak_decay = wr_data[DECAY_WIDTH-1:0];
          REG_HOLD_DECAY:   hold_decay = wr_data[HOLD_DECAY_WIDTH-1:0];
          default: ;
        endcase
      end
      in_sent <= meter_in.valid && meter_in.ready;
      if (meter_in.valid && meter_in.ready) begin
        expected_readings.push_back(advance_meter(
            '{left: meter_in.left_level, right: meter_in.right_level,
              elapsed: meter_in.elapsed_samples}));
        updates_taken++;
      end
      if (meter_out.valid && meter_out.ready) begin
        if (expected_readings.size() == 0) begin
          $error("reading arrived with no update waiting for it");
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          compare_field("left_peak_db", want.peak_l, meter_out.left_peak_db);
          compare_field("right_peak_db", want.peak_r, meter_out.right_peak_db);
          compare_field("left_hold_db", want.left_hold, meter_out.left_hold_db);
          compare_field("right_hold_db", want.right_hold, meter_out.right_hold_db);
          readings_checked++;
        end
      end
    end
  end

  // Sender: presents the next pending update once the previous one has gone, with a
  // random gap of idle cycles in between.
  always @(negedge clk) begin : update_driver
    meter_update_t nxt;
    if (rst) begin
      meter_in.valid <= 1'b0;
      gap_left       <= 0;
    end else if (!meter_in.valid || in_sent) begin
      if (gap_left != 0) begin
        meter_in.valid <= 1'b0;
        gap_left       <= gap_left - 1;
      end else if (pending_updates.size() != 0) begin
        nxt = pending_updates.pop_front();
        meter_in.valid           <= 1'b1;
        meter_in.left_level      <= nxt.left;
        meter_in.right_level     <= nxt.right;
        meter_in.elapsed_samples <= nxt.elapsed;
        gap_left                 <= draw_gap();
      end else begin
        meter_in.valid <= 1'b0;
      end
    end
  end

  // Receiver: holds ready high except during random stalls.
  always @(negedge clk) begin
    if (rst) begin
      meter_out.ready <= 1'b0;
      stall_left      <= 0;
    end else if (stall_left != 0) begin
      meter_out.ready <= 1'b0;
      stall_left      <= stall_left - 1;
    end else begin
      meter_out.ready <= 1'b1;
      stall_left      <= draw_gap();
    end
  end

  // Waits until the sender has nothing left and every reading has come back. The
  // check runs at the rising edge, where the bus is settled, and a grace period
  // follows before the task returns.
  task automatic wait_for_idle();
    @(posedge clk);
    while (pending_updates.size() != 0 || meter_in.valid || expected_readings.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] data);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(negedge clk);
    wr_en    <= 1'b0;
  endtask

  // Writes all three registers. The data words may carry bits above a register's
  // width, which the block must drop.
  task automatic set_meter_config(input logic [CFG_DATA_WIDTH-1:0] hold_v,
                                  input logic [CFG_DATA_WIDTH-1:0] decay_v,
                                  input logic [CFG_DATA_WIDTH-1:0] hold_decay_v);
    write_reg(REG_HOLD_SAMPLES, hold_v);
    write_reg(REG_DECAY, decay_v);
    write_reg(REG_HOLD_DECAY, hold_decay_v);
    settings_used++;
  endtask

  // Random updates in chunks. Each chunk switches idling on or off, so some stretches
  // run back to back; about one chunk in three ends with a full pause until every
  // reading has arrived.
  task automatic run_random(input int unsigned count);
    int unsigned done;
    int unsigned chunk;
    done = 0;
    while (done < count) begin
      chunk = $urandom_range(20, 60);
      if (chunk > count - done) chunk = count - done;
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int unsigned k = 0; k < chunk; k++)
        queue_update(pick_level(), pick_level(), pick_elapsed());
      done += chunk;
      if ($urandom_range(0, 2) == 0) begin
        wait_for_idle();
      end else begin
        while (pending_updates.size() != 0) @(posedge clk);
      end
    end
  endtask

  initial begin
    rst                      = 1'b1;
    wr_en                    = 1'b0;
    wr_index                 = '0;
    wr_data                  = '0;
    meter_in.valid           = 1'b0;
    meter_in.left_level      = '0;
    meter_in.right_level     = '0;
    meter_in.elapsed_samples = '0;
    meter_out.ready          = 1'b0;
    gaps_on                  = 1'b1;
    cycle_count              = 0;
    mismatches               = 0;
    updates_taken            = 0;
    readings_checked         = 0;
    settings_used            = 1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: a 48000-sample hold with the default decays.
    // A louder left channel rises out of silence while no time passes.
    queue_update(LW'(0), SILENCE_LVL, '0);
    // Full scale on both sides, then the longest gap between updates, repeated until
    // both peaks and holds have fallen through -100 dB into silence.
    queue_update(MAX_LVL, MAX_LVL, ELAPSED_WIDTH'(1));
    for (int k = 0; k < 10; k++) queue_update(SILENCE_LVL, SILENCE_LVL, '1);
    // 270 above the floor falls by 10 x 27 to exactly -100 dB and must be kept;
    // the right channel lands on the floor itself and is shown as -96 dB.
    queue_update(FLOOR_LVL + LW'(270), FLOOR_LVL, ELAPSED_WIDTH'(10));
    // Just below and just above the floor, with no time passing.
    queue_update(FLOOR_LVL - LW'(1), FLOOR_LVL + LW'(1), '0);
    // The hold timer runs out while the hold sits at or near the floor, so the hold
    // goes silent.
    queue_update(SILENCE_LVL, SILENCE_LVL, ELAPSED_WIDTH'(48000));
    // Either side of zero, and a level one step above silence.
    queue_update(LW'(-1), LW'(1), ELAPSED_WIDTH'(100));
    queue_update(SILENCE_LVL + LW'(1), SHOW_LVL, ELAPSED_WIDTH'(16'h5555));
    queue_update(LW'(24'h555555), LW'(24'hAAAAAA), ELAPSED_WIDTH'(16'hAAAA));
    wait_for_idle();
    run_random(150);

    // Hold disabled and no peak decay. The unused register index is also written with
    // every bit set, which must change nothing.
    wait_for_idle();
    set_meter_config('0, '0, 20'd255);
    write_reg(REG_SPARE, '1);
    queue_update(MAX_LVL, LW'(0), ELAPSED_WIDTH'(5));
    queue_update(LW'(0), MAX_LVL, '1);
    run_random(150);

    // Longest hold and fastest peak decay, with no hold decay. The data words have
    // their upper bits set so that masking is exercised.
    wait_for_idle();
    set_meter_config('1, '1, 20'hFFF00);
    // A full-scale fall so large that it would wrap without care.
    queue_update(MAX_LVL, MAX_LVL, '1);
    queue_update(FLOOR_LVL + LW'(1), SILENCE_LVL, ELAPSED_WIDTH'(1));
    run_random(150);

    // The smallest nonzero settings.
    wait_for_idle();
    set_meter_config(20'd1, 20'd1, 20'd1);
    run_random(150);

    // Random settings with musically plausible rates; upper bits of the decay words are random.
    for (int p = 0; p < 4; p++) begin
      wait_for_idle();
      set_meter_config(($urandom_range(0, 4) == 0) ? '0 :
                         CFG_DATA_WIDTH'($urandom_range(1, 4000)),
                       {CFG_DATA_WIDTH'($urandom()) & 20'hF0000} |
                         CFG_DATA_WIDTH'($urandom_range(0, 300)),
                       {CFG_DATA_WIDTH'($urandom()) & 20'hFFF00} |
                         CFG_DATA_WIDTH'($urandom_range(0, 255)));
      run_random(150);
    end

    wait_for_idle();
    $display("Sent %0d meter updates and checked %0d readings across %0d register settings,",
             updates_taken, readings_checked, settings_used);
    $display("including hold disabled, extreme decays, masked data and the unused index.");
    if (mismatches == 0) begin
      $display("stereo_peak_meter_with_hold_test: PASS");
    end else begin
      $display("%0d field mismatches.", mismatches);
      $display("stereo_peak_meter_with_hold_test: FAIL");
    end
    $finish;
  end

endmodule

[stereo_peak_meter_with_hold.f]
+incdir+rtl/core
rtl/core/spm_pkg.sv
rtl/core/spm_if.sv
rtl/core/spm_chan.sv
rtl/core/stereo_peak_meter_with_hold.sv
rtl/core/spm_checker.sv
bench/stereo_peak_meter_with_hold_test.sv
